// File: design/bba_pkg.sv
// Shared constants and helpers for the buddy block allocator.
// No dependencies.
package bba_pkg;

    localparam int POOL_UNITS_DEF = 2048;

    localparam int CMD_W    = 1;
    localparam int REQ_W    = 12;
    localparam int FADDR_W  = 11;
    localparam int STATUS_W = 2;
    localparam int BADDR_W  = 11;
    localparam int BSIZE_W  = 12;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // Log2 of the largest power of two that fits in the pool.
    function automatic int f_top_order(input int units);
        int k;
        k = 0;
        while ((k < 30) && ((1 << (k + 1)) <= units)) begin
            k = k + 1;
        end
        return k;
    endfunction

endpackage

// File: design/bba_if.sv
// Request and response channel interfaces for the buddy block allocator.
// Depends on bba_pkg.
interface bba_req_if
    import bba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [REQ_W-1:0]     request_size;
    logic [FADDR_W-1:0]   free_address;

    modport source (output valid, cmd, request_size, free_address, input ready);
    modport sink   (input valid, cmd, request_size, free_address, output ready);
endinterface

interface bba_rsp_if
    import bba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [BADDR_W-1:0]   block_address;
    logic [BSIZE_W-1:0]   block_size;

    modport source (output valid, status, block_address, block_size, input ready);
    modport sink   (input valid, status, block_address, block_size, output ready);
endinterface

// File: design/bba_mem.sv
// Block descriptor memory: one entry per unit, one write and one read port.
// Read data is registered. Depends on nothing.
module bba_mem #(
    parameter int AW = 11,
    parameter int EW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [EW-1:0] o_rdata
);
    localparam int DEPTH = 1 << AW;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/bba_ctrl.sv
// Sequencer of the buddy allocator: scan, split, free and merge steps
// over the descriptor memory, plus the result register. Depends on bba_pkg.
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int TOP = 11,
    parameter int AW  = 11,
    parameter int OW  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [REQ_W-1:0]     i_request_size,
    input  logic [FADDR_W-1:0]   i_free_address,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BADDR_W-1:0]   o_block_address,
    output logic [BSIZE_W-1:0]   o_block_size,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [OW+1:0]        o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    input  logic [OW+1:0]        i_rdata
);
    localparam int SW = (TOP + 1 > REQ_W) ? TOP + 1 : REQ_W;
    localparam int XW = ((AW > FADDR_W) ? AW : FADDR_W) + 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_AEV  = 4'd2;
    localparam logic [3:0] S_ASPL = 4'd3;
    localparam logic [3:0] S_FEV  = 4'd4;
    localparam logic [3:0] S_MEV  = 4'd5;
    localparam logic [3:0] S_MFIN = 4'd6;
    localparam logic [3:0] S_ERR  = 4'd7;

    localparam logic [OW-1:0] TOP_ORD = OW'(TOP);

    logic [3:0]          r_state, n_state;
    logic [AW-1:0]       r_a, n_a;
    logic [OW-1:0]       r_ord, n_ord;
    logic [SW-1:0]       r_want, n_want;
    logic [STATUS_W-1:0] r_err, n_err;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_ov, n_ov;
    logic [STATUS_W-1:0] r_st, n_st;
    logic [BADDR_W-1:0]  r_oaddr, n_oaddr;
    logic [BSIZE_W-1:0]  r_osize, n_osize;

    logic          cap;
    logic          emit;
    logic          rd_start, rd_used;
    logic [OW-1:0] rd_ord;
    logic [SW-1:0] rd_size, half;
    logic [AW:0]   nxt;
    logic [AW-1:0] bit_m;

    assign rd_start = i_rdata[OW+1];
    assign rd_used  = i_rdata[OW];
    assign rd_ord   = i_rdata[OW-1:0];
    assign rd_size  = SW'(1) << rd_ord;
    assign half     = (SW'(1) << r_ord) >> 1;
    assign nxt      = {1'b0, r_a} + ((AW+1)'(1) << rd_ord);
    assign bit_m    = AW'(1) << r_ord;
    assign cap      = !r_ov || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_ord   = r_ord;
        n_want  = r_want;
        n_err   = r_err;
        n_clr   = r_clr;
        n_st    = r_st;
        n_oaddr = r_oaddr;
        n_osize = r_osize;
        emit    = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_a;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = r_a;
        o_req_ready = (r_state == S_IDLE);
        case (r_state)
            S_CLR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = (r_clr == '0) ? {1'b1, 1'b0, TOP_ORD} : '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_cmd == CMD_ALLOC) begin
                        n_want = (i_request_size == '0) ? SW'(1) : SW'(i_request_size);
                        if (n_want > (SW'(1) << TOP)) begin
                            n_err   = ST_NO_SPACE;
                            n_state = S_ERR;
                        end else begin
                            n_a     = '0;
                            o_re    = 1'b1;
                            o_raddr = '0;
                            n_state = S_AEV;
                        end
                    end else begin
                        if (XW'(i_free_address) >= (XW'(1) << TOP)) begin
                            n_err   = ST_BAD_FREE;
                            n_state = S_ERR;
                        end else begin
                            n_a     = AW'(i_free_address);
                            o_re    = 1'b1;
                            o_raddr = AW'(i_free_address);
                            n_state = S_FEV;
                        end
                    end
                end
            end
            S_AEV: begin
                if (!rd_used && rd_size >= r_want) begin
                    n_ord   = rd_ord;
                    n_state = S_ASPL;
                end else if (nxt[AW]) begin
                    n_err   = ST_NO_SPACE;
                    n_state = S_ERR;
                end else begin
                    n_a     = nxt[AW-1:0];
                    o_re    = 1'b1;
                    o_raddr = nxt[AW-1:0];
                end
            end
            S_ASPL: begin
                if (r_ord != '0 && half >= r_want) begin
                    o_we    = 1'b1;
                    o_waddr = r_a + AW'(half);
                    o_wdata = {1'b1, 1'b0, r_ord - OW'(1)};
                    n_ord   = r_ord - OW'(1);
                end else if (cap) begin
                    o_we    = 1'b1;
                    o_wdata = {1'b1, 1'b1, r_ord};
                    emit    = 1'b1;
                    n_st    = ST_OK;
                    n_oaddr = BADDR_W'(r_a);
                    n_osize = BSIZE_W'(SW'(1) << r_ord);
                    n_state = S_IDLE;
                end
            end
            S_FEV: begin
                if (cap) begin
                    emit = 1'b1;
                    if (!rd_start || !rd_used) begin
                        n_st    = ST_BAD_FREE;
                        n_oaddr = '0;
                        n_osize = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_st    = ST_OK;
                        n_oaddr = BADDR_W'(r_a);
                        n_osize = BSIZE_W'(rd_size);
                        n_ord   = rd_ord;
                        if (rd_ord < TOP_ORD) begin
                            o_re    = 1'b1;
                            o_raddr = r_a ^ (AW'(1) << rd_ord);
                            n_state = S_MEV;
                        end else begin
                            o_we    = 1'b1;
                            o_wdata = {1'b1, 1'b0, rd_ord};
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_MEV: begin
                if (rd_start && !rd_used && rd_ord == r_ord) begin
                    // Buddy is whole and free: drop the upper start, grow the lower one.
                    o_we    = 1'b1;
                    o_waddr = r_a | bit_m;
                    o_wdata = '0;
                    n_a     = r_a & ~bit_m;
                    n_ord   = r_ord + OW'(1);
                    if (n_ord < TOP_ORD) begin
                        o_re    = 1'b1;
                        o_raddr = n_a ^ (AW'(1) << n_ord);
                    end else begin
                        n_state = S_MFIN;
                    end
                end else begin
                    o_we    = 1'b1;
                    o_wdata = {1'b1, 1'b0, r_ord};
                    n_state = S_IDLE;
                end
            end
            S_MFIN: begin
                o_we    = 1'b1;
                o_wdata = {1'b1, 1'b0, r_ord};
                n_state = S_IDLE;
            end
            S_ERR: begin
                if (cap) begin
                    emit    = 1'b1;
                    n_st    = r_err;
                    n_oaddr = '0;
                    n_osize = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ov = emit ? 1'b1 : (i_rsp_ready ? 1'b0 : r_ov);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
        r_a     <= n_a;
        r_ord   <= n_ord;
        r_want  <= n_want;
        r_err   <= n_err;
        r_st    <= n_st;
        r_oaddr <= n_oaddr;
        r_osize <= n_osize;
    end

    assign o_rsp_valid     = r_ov;
    assign o_status        = r_st;
    assign o_block_address = r_oaddr;
    assign o_block_size    = r_osize;
endmodule

// File: design/buddy_block_allocator_top.sv
// Buddy block allocator. An allocate scans blocks in address order, halves the chosen block
// as far as the request allows and then grants it; a free gives its result first and then,
// below the top order, merges level by level and ends with a closing write.
// One item is in work at a time; a result waits in an output register.
// Reset is synchronous, active low; a clearing pass then writes all 2^floor(log2(POOL_UNITS))
// descriptor entries before the first beat. Uses bba_pkg, bba_if, bba_mem, bba_ctrl.
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int POOL_UNITS = POOL_UNITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);
    // Only the largest power-of-two prefix of the pool is managed.
    localparam int TOP = f_top_order(POOL_UNITS);
    // Unit address width inside the managed pool.
    localparam int AW  = TOP;
    // Order field width: enough to hold the top order.
    localparam int OW  = $clog2(TOP + 1);

    // Each descriptor entry holds {block start, in use, order}.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [OW+1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [OW+1:0] mem_rdata;

    bba_mem #(
        .AW(AW),
        .EW(OW + 2)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The sequencer walks blocks in address order on allocate, splits the chosen
    // block down one level per cycle, and on free merges with the buddy level by level.
    bba_ctrl #(
        .TOP(TOP),
        .AW (AW),
        .OW (OW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req.valid),
        .o_req_ready     (i_req.ready),
        .i_cmd           (i_req.cmd),
        .i_request_size  (i_req.request_size),
        .i_free_address  (i_req.free_address),
        .o_rsp_valid     (o_rsp.valid),
        .i_rsp_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_block_address (o_rsp.block_address),
        .o_block_size    (o_rsp.block_size),
        .o_we            (mem_we),
        .o_waddr         (mem_waddr),
        .o_wdata         (mem_wdata),
        .o_re            (mem_re),
        .o_raddr         (mem_raddr),
        .i_rdata         (mem_rdata)
    );
endmodule

// File: design/bba_checker.sv
// Port-level checks for the buddy block allocator, bound to the top level.
// Depends on bba_pkg.
module bba_checker
    import bba_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [BADDR_W-1:0]  i_block_address,
    input logic [BSIZE_W-1:0]  i_block_size
);
    a_no_rsp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid) else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
        && $stable(i_block_address) && $stable(i_block_size))
        else $error("stalled response changed");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_OK |-> i_block_address == '0 && i_block_size == '0)
        else $error("error response carries a block");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_status == ST_OK || i_status == ST_NO_SPACE
        || i_status == ST_BAD_FREE) else $error("undefined status");
endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_block_address (o_rsp.block_address),
    .i_block_size    (o_rsp.block_size)
);

// File: sim/bba_pool_checker.sv
// Pool checker for the buddy block allocator: watches both channels, keeps its own
// copy of the block descriptors, predicts every response beat and compares it.
// Depends on bba_pkg and bba_if.
module bba_pool_checker
    import bba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    bba_req_if    i_req_mon,
    bba_rsp_if    i_rsp_mon,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL      = POOL_UNITS_DEF;
    localparam int TOP_ORDER = $clog2(POOL + 1) - 1;
    localparam int MANAGED   = 1 << TOP_ORDER;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BADDR_W-1:0]  address;
        logic [BSIZE_W-1:0]  size;
    } t_grant;

    logic [3:0] blk_order [POOL];
    bit         blk_start [POOL];
    bit         blk_busy  [POOL];
    t_grant     expected_grants [$];
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_grants.size();

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Allocate walks blocks in address order and splits the first fit down;
    // free releases a block and merges it with its buddy while possible.
    function automatic t_grant pool_operation(input logic [CMD_W-1:0] cmd,
                                              input logic [REQ_W-1:0] want_in,
                                              input logic [FADDR_W-1:0] faddr);
        t_grant r;
        int a, ord, size, want, b, hi;
        r = '{status: ST_NO_SPACE, address: '0, size: '0};
        if (cmd == CMD_ALLOC) begin
            want = (want_in == 0) ? 1 : int'(want_in);
            if (want > MANAGED) return r;
            a = 0;
            while (a < MANAGED) begin
                ord  = int'(blk_order[a]);
                size = 1 << ord;
                if (!blk_busy[a] && size >= want) begin
                    while (ord > 0 && (size >> 1) >= want) begin
                        size = size >> 1;
                        ord--;
                        blk_order[a]        = 4'(ord);
                        blk_order[a + size] = 4'(ord);
                        blk_start[a + size] = 1'b1;
                        blk_busy[a + size]  = 1'b0;
                    end
                    blk_busy[a] = 1'b1;
                    r = '{status: ST_OK, address: BADDR_W'(a), size: BSIZE_W'(size)};
                    return r;
                end
                a += size;
            end
            return r;
        end
        r.status = ST_BAD_FREE;
        a = int'(faddr);
        if (a >= MANAGED || !blk_start[a] || !blk_busy[a]) return r;
        ord = int'(blk_order[a]);
        blk_busy[a] = 1'b0;
        r = '{status: ST_OK, address: BADDR_W'(a), size: BSIZE_W'(1 << ord)};
        while (ord < TOP_ORDER) begin
            b = a ^ (1 << ord);
            if (b >= MANAGED || !blk_start[b] || blk_busy[b] || int'(blk_order[b]) != ord)
                break;
            hi = (a > b) ? a : b;
            a  = (a < b) ? a : b;
            blk_start[hi] = 1'b0;
            blk_order[hi] = '0;
            ord++;
            blk_order[a] = 4'(ord);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_grant got, want;
        if (!i_rst_n) begin
            for (int k = 0; k < POOL; k++) begin
                blk_order[k] = '0;
                blk_start[k] = 1'b0;
                blk_busy[k]  = 1'b0;
            end
            blk_order[0] = 4'(TOP_ORDER);
            blk_start[0] = 1'b1;
            expected_grants.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready)
                expected_grants.push_back(pool_operation(i_req_mon.cmd,
                    i_req_mon.request_size, i_req_mon.free_address));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = '{status: i_rsp_mon.status, address: i_rsp_mon.block_address,
                        size: i_rsp_mon.block_size};
                if (expected_grants.size() == 0) begin
                    report("unexpected response beat", 1, 0);
                end else begin
                    want = expected_grants.pop_front();
                    if (got.status !== want.status) report("status", got.status, want.status);
                    if (got.address !== want.address)
                        report("block_address", got.address, want.address);
                    if (got.size !== want.size) report("block_size", got.size, want.size);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

// File: sim/buddy_block_allocator_top_tb.sv
// Testbench top for the buddy block allocator: makes request traffic, throttles the
// response channel, and gives the verdict from the pool checker's failure count.
// Depends on bba_pkg, bba_if, bba_pool_checker and the allocator RTL.
module buddy_block_allocator_top_tb;
    import bba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The worst gap between beats is a full scan of a fragmented pool plus the
    // clearing pass after reset.
    localparam int STALL_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 1100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    bba_pool_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_mon   (req_ch),
        .i_rsp_mon   (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Every input starts at a known value before the first edge.
    initial begin
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_ALLOC;
        req_ch.request_size = '0;
        req_ch.free_address = '0;
        rsp_ch.ready        = 1'b0;
    end

    // The receiver alternates between stretches where it is ready on most beats and stretches
    // where it stalls most beats, so back-pressure lands on every phase.
    int  stall_phase_left = 0;
    bit  stall_heavy = 1'b0;
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_heavy      <= ($urandom_range(0, 2) == 0);
            stall_phase_left <= $urandom_range(20, 300);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        if (stall_heavy)
            rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        else
            rsp_ch.ready <= ($urandom_range(0, 7) != 0);
    end

    // Tracks the starts of currently granted blocks so that most frees are legal.
    logic [CMD_W-1:0]   cmds_in_flight [$];
    logic [BADDR_W-1:0] live_blocks [$];
    always @(posedge i_clk) begin
        logic [CMD_W-1:0] c;
        int hit [$];
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) cmds_in_flight.push_back(req_ch.cmd);
            if (rsp_ch.valid && rsp_ch.ready && cmds_in_flight.size() > 0) begin
                c = cmds_in_flight.pop_front();
                if (rsp_ch.status == ST_OK) begin
                    if (c == CMD_ALLOC) begin
                        live_blocks.push_back(rsp_ch.block_address);
                    end else begin
                        hit = live_blocks.find_first_index(x) with (x == rsp_ch.block_address);
                        if (hit.size() > 0) live_blocks.delete(hit[0]);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("buddy_block_allocator_top_tb: FAIL");
            $finish;
        end
    end

    // Holds valid high until the beat is taken. Valid is left high afterwards so
    // that a back-to-back beat never lowers and raises it in one step.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] size,
                                input logic [FADDR_W-1:0] addr);
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= cmd;
        req_ch.request_size <= size;
        req_ch.free_address <= addr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Mostly small sizes so the pool fragments; a few large, whole-pool and oversized.
    function automatic logic [REQ_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)  return '0;
        if (r < 70) return REQ_W'($urandom_range(1, 16));
        if (r < 90) return REQ_W'($urandom_range(17, 256));
        if (r < 97) return REQ_W'($urandom_range(257, 2048));
        return REQ_W'($urandom_range(2049, 4095));
    endfunction

    initial begin
        int burst_left;
        logic [FADDR_W-1:0] addr;
        burst_left = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero, whole-pool and oversized requests, a full pool,
        // frees of free blocks, of mid-block addresses, double frees and merges.
        send_request(CMD_ALLOC, 12'd0, 11'h7FF);
        send_request(CMD_FREE, 12'hFFF, 11'd0);
        send_request(CMD_FREE, 12'd0, 11'd0);
        send_request(CMD_ALLOC, 12'd2048, 11'd0);
        send_request(CMD_ALLOC, 12'd1, 11'd0);
        send_request(CMD_FREE, 12'd0, 11'd1024);
        send_request(CMD_FREE, 12'd0, 11'd0);
        send_request(CMD_ALLOC, 12'd4095, 11'd0);
        send_request(CMD_ALLOC, 12'd2049, 11'd0);
        send_request(CMD_ALLOC, 12'd1, 11'd0);
        send_request(CMD_ALLOC, 12'd1, 11'd0);
        send_request(CMD_ALLOC, 12'd3, 11'd0);
        send_request(CMD_ALLOC, 12'd1025, 11'd0);
        send_request(CMD_ALLOC, 12'd1024, 11'd0);
        send_request(CMD_FREE, 12'd0, 11'd5);
        send_request(CMD_FREE, 12'd0, 11'd1024);
        send_request(CMD_FREE, 12'd0, 11'd1);
        send_request(CMD_FREE, 12'd0, 11'd1);
        send_request(CMD_FREE, 12'd0, 11'd0);
        send_request(CMD_FREE, 12'd0, 11'd4);
        send_request(CMD_ALLOC, 12'd1024, 11'd0);
        send_request(CMD_ALLOC, 12'd1024, 11'd0);
        send_request(CMD_FREE, 12'd0, 11'd0);
        send_request(CMD_FREE, 12'd0, 11'd1024);
        idle_for(1);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Let the pipeline drain completely once in the middle of the run.
            if (n == RANDOM_ITEMS / 2) begin
                idle_for(1);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 1) == 0) begin
                send_request(CMD_ALLOC, pick_size(), FADDR_W'($urandom_range(0, 2047)));
            end else begin
                if (live_blocks.size() > 0 && $urandom_range(0, 4) != 0)
                    addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                else
                    addr = FADDR_W'($urandom_range(0, 2047));
                send_request(CMD_FREE, REQ_W'($urandom_range(0, 4095)), addr);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
            end else begin
                burst_left--;
            end
        end
        idle_for(1);

        while (pending != 0) @(posedge i_clk);
        // A free may still be merging after its result; give it time to settle.
        repeat (64) @(posedge i_clk);
        if (fail_count == 0)
            $display("buddy_block_allocator_top_tb: PASS");
        else
            $display("buddy_block_allocator_top_tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/bba_pkg.sv
design/bba_if.sv
design/bba_mem.sv
design/bba_ctrl.sv
design/buddy_block_allocator_top.sv
design/bba_checker.sv
sim/bba_pool_checker.sv
sim/buddy_block_allocator_top_tb.sv
